>>> sv/polygon_scale_about_center_unit_assert.svh
// ----------------------------------------------------------------
// Assertion macros for the polygon scaling unit
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------
`ifndef POLYGON_SCALE_ABOUT_CENTER_UNIT_ASSERT_SVH
`define POLYGON_SCALE_ABOUT_CENTER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PSAC_ASSERT_IMPL(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PSAC_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/psac_pkg.sv
// ----------------------------------------------------------------
// Polygon scaling package
// Fixed constants, register codes and shared status types.
// ----------------------------------------------------------------
package psac_pkg;

	localparam int SCALE_W     = 16;
	localparam int SCALE_ONE   = 256;
	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
	localparam int DIV_SHIFT   = 9;
	localparam int DIV_BIAS    = (1 << DIV_SHIFT) - 1;
	localparam int CFG_DATA_W  = 32;
	localparam int PADDR_W     = 3;

	typedef enum logic [0:0] {
		REG_SCALE_FACTOR = 1'b0
	} reg_idx_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} job_status_t;

endpackage

>>> sv/psac_ram.sv
// ----------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------
module psac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/psac_front.sv
// ----------------------------------------------------------------
// Polygon loader
// Accepts vertices, stores them and tracks the bounding box; on the
// final vertex it hands a job to the back end.
// ----------------------------------------------------------------
module psac_front #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16,
	localparam int IDX_W = $clog2(MAX_VERTICES),
	localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic                          last_vertex,
	input  psac_pkg::job_status_t         job_status,
	output logic                          wr_en,
	output logic [IDX_W:0]                wr_addr,
	output logic [2*COORD_BITS-1:0]       wr_data,
	output logic                          job_push,
	output logic                          job_bank,
	output logic [CNT_W-1:0]              job_count,
	output logic signed [COORD_BITS:0]    job_sx,
	output logic signed [COORD_BITS:0]    job_sy
);

	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [CNT_W-1:0]             count_q;
	logic                         bank_q;
	logic signed [COORD_BITS-1:0] low_x_q, high_x_q, low_y_q, high_y_q;
	logic signed [COORD_BITS-1:0] low_x_n, high_x_n, low_y_n, high_y_n;
	logic                         accept;
	logic                         store;

	always_comb begin
		accept   = in_valid && !job_status.full;
		store    = accept && (count_q != CNT_W'(MAX_VERTICES));
		low_x_n  = (store && (point_x < low_x_q))  ? point_x : low_x_q;
		high_x_n = (store && (point_x > high_x_q)) ? point_x : high_x_q;
		low_y_n  = (store && (point_y < low_y_q))  ? point_y : low_y_q;
		high_y_n = (store && (point_y > high_y_q)) ? point_y : high_y_q;
	end

	assign in_ready  = !job_status.full;
	assign wr_en     = store;
	assign wr_addr   = {bank_q, count_q[IDX_W-1:0]};
	assign wr_data   = {point_y, point_x};
	assign job_push  = accept && last_vertex;
	assign job_bank  = bank_q;
	assign job_count = count_q + CNT_W'(store);
	assign job_sx    = {low_x_n[COORD_BITS-1], low_x_n} + {high_x_n[COORD_BITS-1], high_x_n};
	assign job_sy    = {low_y_n[COORD_BITS-1], low_y_n} + {high_y_n[COORD_BITS-1], high_y_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			bank_q   <= 1'b0;
			low_x_q  <= COORD_MAX;
			low_y_q  <= COORD_MAX;
			high_x_q <= COORD_MIN;
			high_y_q <= COORD_MIN;
		end else if (accept) begin
			if (last_vertex) begin
				count_q  <= '0;
				bank_q   <= !bank_q;
				low_x_q  <= COORD_MAX;
				low_y_q  <= COORD_MAX;
				high_x_q <= COORD_MIN;
				high_y_q <= COORD_MIN;
			end else begin
				count_q  <= job_count;
				low_x_q  <= low_x_n;
				low_y_q  <= low_y_n;
				high_x_q <= high_x_n;
				high_y_q <= high_y_n;
			end
		end
	end

endmodule

>>> sv/psac_job_queue.sv
// ----------------------------------------------------------------
// Job queue
// Two-entry queue of polygon jobs between the loader and the emitter.
// ----------------------------------------------------------------
module psac_job_queue #(
	parameter int WIDTH = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      head,
	output psac_pkg::job_status_t status
);

	logic [WIDTH-1:0] entry_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;

	assign head             = entry_q[rd_ptr_q];
	assign status.not_empty = (cnt_q != 2'd0);
	assign status.full      = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> sv/psac_back.sv
// ----------------------------------------------------------------
// Vertex emitter
// Replays the stored vertices of a job through the scaling pipeline
// into a small output queue.
// ----------------------------------------------------------------
module psac_back #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16,
	localparam int IDX_W = $clog2(MAX_VERTICES),
	localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [psac_pkg::SCALE_W-1:0]        scale_factor,
	input  psac_pkg::job_status_t               job_status,
	input  logic                                job_bank,
	input  logic [CNT_W-1:0]                    job_count,
	input  logic signed [COORD_BITS:0]          job_sx,
	input  logic signed [COORD_BITS:0]          job_sy,
	output logic                                job_pop,
	output logic                                rd_en,
	output logic [IDX_W:0]                      rd_addr,
	input  logic [2*COORD_BITS-1:0]             rd_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [COORD_BITS-1:0]               scaled_x,
	output logic [COORD_BITS-1:0]               scaled_y,
	output logic                                last_out
);

	localparam int SW    = psac_pkg::SCALE_W;
	localparam int K_W   = SW + 2;
	localparam int PA_W  = COORD_BITS + SW + 1;
	localparam int PB_W  = COORD_BITS + SW + 3;
	localparam int NUM_W = COORD_BITS + SW + 4;
	localparam int Q_W   = NUM_W - psac_pkg::DIV_SHIFT;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);

	function automatic logic [COORD_BITS-1:0] sat_coord(input logic [NUM_W-1:0] num);
		logic [NUM_W-1:0] biased;
		logic [Q_W-1:0]   q;
		biased = num + (num[NUM_W-1] ? NUM_W'(psac_pkg::DIV_BIAS) : '0);
		q      = biased[NUM_W-1:psac_pkg::DIV_SHIFT];
		if ((q[Q_W-1:COORD_BITS-1] == '0) || (q[Q_W-1:COORD_BITS-1] == '1)) begin
			return q[COORD_BITS-1:0];
		end else if (q[Q_W-1]) begin
			return {1'b1, {(COORD_BITS-1){1'b0}}};
		end else begin
			return {1'b0, {(COORD_BITS-1){1'b1}}};
		end
	endfunction

	logic [IDX_W-1:0]             idx_q;
	logic                         issue, issue_last;
	logic [OQ_AW:0]               oq_cnt_q;
	logic [OQ_AW-1:0]             oq_wr_q, oq_rd_q;
	logic [COORD_BITS-1:0]        oq_x_q [OQ_DEPTH];
	logic [COORD_BITS-1:0]        oq_y_q [OQ_DEPTH];
	logic                         oq_last_q [OQ_DEPTH];
	logic                         oq_pop;

	logic                         v_s1, last_s1;
	logic signed [COORD_BITS:0]   sx_s1, sy_s1;
	logic                         v_s2, last_s2;
	logic signed [PA_W-1:0]       pax_s2, pay_s2;
	logic signed [PB_W-1:0]       pbx_s2, pby_s2;

	logic signed [COORD_BITS-1:0] px, py;
	logic signed [K_W-1:0]        k;
	logic signed [SW:0]           f_s;
	logic signed [PA_W-1:0]       pax, pay;
	logic signed [PB_W-1:0]       pbx, pby;
	logic [NUM_W-1:0]             num_x, num_y;

	always_comb begin
		issue      = job_status.not_empty &&
			((oq_cnt_q + (OQ_AW+1)'(v_s1) + (OQ_AW+1)'(v_s2)) < (OQ_AW+1)'(OQ_DEPTH));
		issue_last = ((CNT_W'(idx_q) + CNT_W'(1)) == job_count);
	end

	assign job_pop = issue && issue_last;
	assign rd_en   = issue;
	assign rd_addr = {job_bank, idx_q};

	always_comb begin
		px    = $signed(rd_data[COORD_BITS-1:0]);
		py    = $signed(rd_data[2*COORD_BITS-1:COORD_BITS]);
		f_s   = $signed({1'b0, scale_factor});
		k     = $signed(K_W'(psac_pkg::SCALE_ONE)) - $signed({2'b00, scale_factor});
		pax   = px * f_s;
		pay   = py * f_s;
		pbx   = sx_s1 * k;
		pby   = sy_s1 * k;
		num_x = {{(NUM_W-PA_W-1){pax_s2[PA_W-1]}}, pax_s2, 1'b0} +
			{{(NUM_W-PB_W){pbx_s2[PB_W-1]}}, pbx_s2};
		num_y = {{(NUM_W-PA_W-1){pay_s2[PA_W-1]}}, pay_s2, 1'b0} +
			{{(NUM_W-PB_W){pby_s2[PB_W-1]}}, pby_s2};
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			last_s1 <= issue_last;
			sx_s1   <= job_sx;
			sy_s1   <= job_sy;
		end
		last_s2 <= last_s1;
		pax_s2  <= pax;
		pay_s2  <= pay;
		pbx_s2  <= pbx;
		pby_s2  <= pby;
		if (v_s2) begin
			oq_x_q[oq_wr_q]    <= sat_coord(num_x);
			oq_y_q[oq_wr_q]    <= sat_coord(num_y);
			oq_last_q[oq_wr_q] <= last_s2;
		end
	end

	assign out_valid = (oq_cnt_q != '0);
	assign oq_pop    = out_valid && out_ready;
	assign scaled_x  = oq_x_q[oq_rd_q];
	assign scaled_y  = oq_y_q[oq_rd_q];
	assign last_out  = oq_last_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			oq_cnt_q <= '0;
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
		end else begin
			if (issue) begin
				idx_q <= issue_last ? '0 : idx_q + IDX_W'(1);
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (v_s2) begin
				oq_wr_q <= oq_wr_q + OQ_AW'(1);
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + OQ_AW'(1);
			end
			oq_cnt_q <= oq_cnt_q + (OQ_AW+1)'(v_s2) - (OQ_AW+1)'(oq_pop);
		end
	end

endmodule

>>> sv/polygon_scale_about_center_unit.sv
// ----------------------------------------------------------------
// Polygon scale about centre unit
// Loads one vertex per cycle unless the job queue is full, and emits one result per cycle
// unless stalled. A two-bank vertex RAM and a two-entry job queue overlap load and emit.
// Reset clears counters, box and queues and sets the factor to 1.0; no clearing pass.
// ----------------------------------------------------------------
module polygon_scale_about_center_unit #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16,
	localparam int TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [TDATA_W-1:0]                s_tdata,  // point_x, point_y
	input  logic                              s_tlast,  // last_vertex
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [TDATA_W-1:0]                m_tdata,  // scaled_x, scaled_y
	output logic                              m_tlast,  // last_out
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [psac_pkg::PADDR_W-1:0]      paddr,
	input  logic [psac_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [psac_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                              pready
);

	localparam int IDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int JOB_W = 1 + CNT_W + 2 * (COORD_BITS + 1);

	logic [psac_pkg::SCALE_W-1:0] scale_q;
	psac_pkg::reg_idx_t           reg_idx;
	psac_pkg::job_status_t        job_status;

	logic                         wr_en, rd_en;
	logic [IDX_W:0]               wr_addr, rd_addr;
	logic [2*COORD_BITS-1:0]      wr_data, rd_data;
	logic                         job_push, job_pop;
	logic                         push_bank, head_bank;
	logic [CNT_W-1:0]             push_count, head_count;
	logic signed [COORD_BITS:0]   push_sx, push_sy, head_sx, head_sy;
	logic [JOB_W-1:0]             head;
	logic [COORD_BITS-1:0]        scaled_x, scaled_y;

	assign pready  = 1'b1;
	assign reg_idx = psac_pkg::reg_idx_t'(paddr[2]);

	always_comb begin
		case (reg_idx)
			psac_pkg::REG_SCALE_FACTOR: prdata = psac_pkg::CFG_DATA_W'(scale_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= psac_pkg::SCALE_RESET;
		end else if (psel && penable && pwrite && pready &&
				(reg_idx == psac_pkg::REG_SCALE_FACTOR)) begin
			scale_q <= pwdata[psac_pkg::SCALE_W-1:0];
		end
	end

	psac_front #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.point_x     ($signed(s_tdata[COORD_BITS-1:0])),
		.point_y     ($signed(s_tdata[2*COORD_BITS-1:COORD_BITS])),
		.last_vertex (s_tlast),
		.job_status  (job_status),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.job_push    (job_push),
		.job_bank    (push_bank),
		.job_count   (push_count),
		.job_sx      (push_sx),
		.job_sy      (push_sy)
	);

	psac_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (1 << (IDX_W + 1))
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	psac_job_queue #(
		.WIDTH (JOB_W)
	) u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data ({push_bank, push_count, push_sx, push_sy}),
		.pop       (job_pop),
		.head      (head),
		.status    (job_status)
	);

	assign {head_bank, head_count, head_sx, head_sy} = head;

	psac_back #(
		.MAX_VERTICES (MAX_VERTICES),
		.COORD_BITS   (COORD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale_factor (scale_q),
		.job_status   (job_status),
		.job_bank     (head_bank),
		.job_count    (head_count),
		.job_sx       (head_sx),
		.job_sy       (head_sy),
		.job_pop      (job_pop),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.scaled_x     (scaled_x),
		.scaled_y     (scaled_y),
		.last_out     (m_tlast)
	);

	assign m_tdata = TDATA_W'({scaled_y, scaled_x});

endmodule

>>> sv/psac_checker.sv
// ----------------------------------------------------------------
// Port checker for the polygon scaling unit
// Watches the output stream and the register port over time.
// ----------------------------------------------------------------
`include "polygon_scale_about_center_unit_assert.svh"

module psac_checker #(
	parameter int COORD_BITS = 16,
	localparam int TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [TDATA_W-1:0]              m_tdata,
	input logic                            m_tlast,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [psac_pkg::PADDR_W-1:0]    paddr,
	input logic [psac_pkg::CFG_DATA_W-1:0] pwdata,
	input logic [psac_pkg::CFG_DATA_W-1:0] prdata,
	input logic                            pready
);

	logic wr_factor;

	assign wr_factor = psel && penable && pwrite && pready && !paddr[2];

	`PSAC_ASSERT_NEXT(a_out_valid_holds, m_tvalid && !m_tready, m_tvalid, "result item withdrawn while stalled")
	`PSAC_ASSERT_NEXT(a_out_item_holds, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "stalled result item changed")
	`PSAC_ASSERT_IMPL(a_ready_high, psel, pready, "register port not ready")
	`PSAC_ASSERT_IMPL(a_factor_readback, $past(arst_n) && $past(wr_factor) && !paddr[2], prdata == {{(psac_pkg::CFG_DATA_W-psac_pkg::SCALE_W){1'b0}}, $past(pwdata[psac_pkg::SCALE_W-1:0])}, "scale factor read back wrong")

endmodule

bind polygon_scale_about_center_unit psac_checker #(.COORD_BITS(COORD_BITS)) u_checker (.*);
